// ===== rtl/core/alist_pkg.sv =====
// Package for the array list engine: sizes, command and status codes,
// the control word broadcast to the storage cells, and the state encoding.
// No dependencies; every other file of the block imports it.
package alist_pkg;

  // List capacity and the widths that follow from it.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths of the transaction payloads.
  localparam int CMD_W   = 3;
  localparam int WORD_W  = 32;
  localparam int POS_W   = 5;
  localparam int STAT_W  = 2;
  localparam int FIDX_W  = 4;
  localparam int ECNT_W  = 5;

  // Width used to compare a position against the count.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR         = 3'd0,
    CMD_INSERT_AT     = 3'd1,
    CMD_DELETE_AT     = 3'd2,
    CMD_LOCATE        = 3'd3,
    CMD_RETRIEVE      = 3'd4,
    CMD_INSERT_SORTED = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // What every cell does in a given cycle.
  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_COMPARE = 2'd1,
    CELL_INSERT  = 2'd2,
    CELL_DELETE  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [IDX_W-1:0]          target;
    logic signed [WORD_W-1:0]  word;
  } cell_ctrl_t;

  // Compare results registered in each cell.
  typedef struct packed {
    logic eq;
    logic lt;
  } cell_flags_t;

  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_COMPARE = 2'd1,
    S_EXEC    = 2'd2
  } state_t;

endpackage

// ===== rtl/core/alist_in_if.sv =====
// Command channel of the array list engine: valid/ready plus the payload.
// Depends on alist_pkg for the field widths.
interface alist_in_if import alist_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [WORD_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink (input valid, input cmd, input value, input position, output ready);
endinterface

// ===== rtl/core/alist_out_if.sv =====
// Result channel of the array list engine: valid/ready plus the payload.
// Depends on alist_pkg for the field widths.
interface alist_out_if import alist_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [FIDX_W-1:0]        found_index;
  logic signed [WORD_W-1:0] read_value;
  logic [ECNT_W-1:0]        entry_count;

  modport source (output valid, output status, output found_index, output read_value,
                  output entry_count, input ready);
  modport sink (input valid, input status, input found_index, input read_value,
                input entry_count, output ready);
endinterface

// ===== rtl/core/array_list_engine_core.sv =====
// Top level of the array list engine: command FSM, count register, a row
// of storage cells and the result register. Uses alist_pkg, alist_cell,
// alist_in_if and alist_out_if.
//
// The list is a row of DEPTH cells, each holding one entry; inserts and
// deletes shift all cells in parallel toward or away from the target.
// Every command runs through idle, compare and execute: the transaction is
// accepted, in the next cycle every cell compares its entry with the command
// value, and in the execute state the first matching or not-less cell is
// priority encoded, the cells shift and the result is loaded into the output
// register. A new command is accepted in the cycle after that, so no command
// is taken before the previous one has executed; the execute state waits
// only while a previous result is still held in the output register. The
// entries are not cleared at reset; only entries below the count are ever read.
module array_list_engine_core import alist_pkg::*; (
  input logic         clk,
  input logic         rst,
  alist_in_if.sink    req,
  alist_out_if.source rsp
);

  state_t state, state_next;
  logic   exec_fire;

  logic [CNT_W-1:0] cnt, cnt_next;

  logic [CMD_W-1:0]         cmd_r;
  logic signed [WORD_W-1:0] value_r;
  logic [POS_W-1:0]         pos_r;

  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic [FIDX_W-1:0]        out_fidx;
  logic signed [WORD_W-1:0] out_rd;
  logic [ECNT_W-1:0]        out_cnt;

  cell_ctrl_t               ctrl;
  cell_op_t                 exec_op;
  logic [IDX_W-1:0]         exec_target;
  logic signed [WORD_W-1:0] entries [DEPTH];
  cell_flags_t              flags [DEPTH];

  logic [DEPTH-1:0] eq_hit;
  logic [DEPTH-1:0] ge_hit;
  logic             loc_found;
  logic [IDX_W-1:0] loc_idx;
  logic [IDX_W-1:0] sort_idx;

  status_t                  res_status;
  logic [IDX_W-1:0]         res_idx;
  logic signed [WORD_W-1:0] res_rd;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             list_full;
  logic [31:0]      idx_wide;
  logic [31:0]      cnt_wide;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (req.valid) state_next = S_COMPARE;
      S_COMPARE: state_next = S_EXEC;
      S_EXEC:    if (exec_fire) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // FSM outputs: ready while idle, execute when the result slot is free.
  always_comb begin
    req.ready = (state == S_IDLE);
    exec_fire = (state == S_EXEC) && (!out_valid || rsp.ready);
  end

  // Capture the command transaction.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_r   <= req.cmd;
      value_r <= req.value;
      pos_r   <= req.position;
    end
  end

  // Compare flags qualified by the entries in use.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      eq_hit[i] = flags[i].eq && (CNT_W'(i) < cnt);
      ge_hit[i] = !flags[i].lt && (CNT_W'(i) < cnt);
    end
  end

  // Priority encoders: first equal entry, and first entry not less.
  always_comb begin
    loc_found = 1'b0;
    loc_idx   = '0;
    sort_idx  = IDX_W'(cnt);
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (eq_hit[i]) begin
        loc_found = 1'b1;
        loc_idx   = IDX_W'(i);
      end
      if (ge_hit[i]) begin
        sort_idx = IDX_W'(i);
      end
    end
  end

  // Command decode: status, result fields, new count and the cell shift.
  always_comb begin
    pos_ext     = CMP_W'(pos_r);
    cnt_ext     = CMP_W'(cnt);
    list_full   = (cnt == CNT_W'(DEPTH));
    res_status  = ST_OK;
    res_idx     = '0;
    res_rd      = '0;
    cnt_next    = cnt;
    exec_op     = CELL_HOLD;
    exec_target = IDX_W'(pos_r);
    unique case (cmd_t'(cmd_r))
      CMD_CLEAR: begin
        cnt_next = '0;
      end
      CMD_INSERT_AT: begin
        if (pos_ext > cnt_ext) begin
          res_status = ST_BAD_POS;
        end else if (list_full) begin
          res_status = ST_FULL;
        end else begin
          exec_op  = CELL_INSERT;
          cnt_next = cnt + 1'b1;
        end
      end
      CMD_DELETE_AT: begin
        if (pos_ext >= cnt_ext) begin
          res_status = ST_BAD_POS;
        end else begin
          exec_op  = CELL_DELETE;
          cnt_next = cnt - 1'b1;
        end
      end
      CMD_LOCATE: begin
        if (loc_found) begin
          res_idx = loc_idx;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      CMD_RETRIEVE: begin
        if (pos_ext >= cnt_ext) begin
          res_status = ST_BAD_POS;
        end else begin
          res_rd = entries[IDX_W'(pos_r)];
        end
      end
      CMD_INSERT_SORTED: begin
        if (list_full) begin
          res_status = ST_FULL;
        end else begin
          exec_op     = CELL_INSERT;
          exec_target = sort_idx;
          cnt_next    = cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control word broadcast to the cells.
  always_comb begin
    ctrl.op     = CELL_HOLD;
    ctrl.target = exec_target;
    ctrl.word   = value_r;
    if (state == S_COMPARE) begin
      ctrl.op = CELL_COMPARE;
    end else if (exec_fire) begin
      ctrl.op = exec_op;
    end
  end

  // Row of storage cells; each end takes its own entry as the outer neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    alist_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .self_index  (IDX_W'(g)),
      .left_entry  ((g == 0) ? entries[g] : entries[(g == 0) ? 0 : g - 1]),
      .right_entry ((g == DEPTH - 1) ? entries[g] : entries[(g == DEPTH - 1) ? g : g + 1]),
      .entry       (entries[g]),
      .flags       (flags[g])
    );
  end

  // Count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (exec_fire) begin
      cnt <= cnt_next;
    end
  end

  // Result register and its valid flag.
  always_comb begin
    idx_wide = 32'(res_idx);
    cnt_wide = 32'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_status <= res_status;
      out_fidx   <= idx_wide[FIDX_W-1:0];
      out_rd     <= res_rd;
      out_cnt    <= cnt_wide[ECNT_W-1:0];
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found_index = out_fidx;
  assign rsp.read_value  = out_rd;
  assign rsp.entry_count = out_cnt;

  // The count never exceeds the capacity of the cell row.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // An accepted command always goes to the compare cycle next.
  a_accept_compare: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_COMPARE))
    else $error("accepted command did not enter compare");

  // A result appears only out of the execute cycle.
  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EXEC))
    else $error("result produced outside execute");

  // The count changes only when a command executes.
  a_cnt_stable: assert property (@(posedge clk) disable iff (rst)
    !exec_fire |=> $stable(cnt))
    else $error("count changed without a command");

endmodule

// ===== rtl/core/alist_cell.sv =====
// One storage cell of the list: holds one entry, compares it with the
// broadcast word and takes its neighbor's entry on a shift. Uses alist_pkg.
module alist_cell import alist_pkg::*; (
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic [IDX_W-1:0]         self_index,
  input  logic signed [WORD_W-1:0] left_entry,
  input  logic signed [WORD_W-1:0] right_entry,
  output logic signed [WORD_W-1:0] entry,
  output cell_flags_t              flags
);

  // Entry update: insert moves entries above the target up by one,
  // delete pulls entries from the target onward down by one.
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (self_index > ctrl.target) begin
          entry <= left_entry;
        end else if (self_index == ctrl.target) begin
          entry <= ctrl.word;
        end
      end
      CELL_DELETE: begin
        if (self_index >= ctrl.target) begin
          entry <= right_entry;
        end
      end
      default: begin
      end
    endcase
  end

  // Signed compare with the broadcast word, kept for the next cycle.
  always_ff @(posedge clk) begin
    if (ctrl.op == CELL_COMPARE) begin
      flags.eq <= (entry == ctrl.word);
      flags.lt <= (entry < ctrl.word);
    end
  end

endmodule
